[rtl/base64_line_wrapped_encoder_macros.svh]
// Assertion shorthands for the encoder checker.
`ifndef BASE64_LINE_WRAPPED_ENCODER_MACROS_SVH
`define BASE64_LINE_WRAPPED_ENCODER_MACROS_SVH

// same-cycle implication, disabled in reset
`define B64E_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled in reset
`define B64E_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/b64e_pkg.sv]
`default_nettype none
package b64e_pkg;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [7:0] LINE_LEN_RST = 8'd76;
	localparam logic [7:0] MIN_LINE     = 8'd4;
	localparam logic [7:0] PAD_CHAR     = 8'h3D;
	localparam logic [7:0] CR_CHAR      = 8'h0D;
	localparam logic [7:0] LF_CHAR      = 8'h0A;

	// one three-byte group headed for the back end
	typedef struct packed {
		logic [23:0] chunk;
		logic [1:0]  pad;   // number of '=' to emit
		logic        fin;   // group closes the message
	} grp_t;

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] r;
		if (v < 6'd26)
			r = 8'h41 + {2'b00, v};
		else if (v < 6'd52)
			r = 8'h61 + {2'b00, v} - 8'd26;
		else if (v < 6'd62)
			r = 8'h30 + {2'b00, v} - 8'd52;
		else if (v == 6'd62)
			r = 8'h2B;
		else
			r = 8'h2F;
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/b64e_front.sv]
`default_nettype none
module b64e_front
	import b64e_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,
	input  wire logic       s_tlast,
	output logic            push_valid,
	input  wire logic       push_ready,
	output grp_t            push_grp
);

	logic [1:0]  fill_q;
	logic [15:0] held_q;
	logic        accept;
	logic        complete;

	assign s_tready   = push_ready;
	assign accept     = s_tvalid && push_ready;
	assign complete   = s_tlast || fill_q[1];
	assign push_valid = s_tvalid && complete;

	always_comb begin
		push_grp.fin = s_tlast;
		case (fill_q)
			2'd0: begin
				push_grp.chunk = {s_tdata, 16'h0000};
				push_grp.pad   = 2'd2;
			end
			2'd1: begin
				push_grp.chunk = {held_q[15:8], s_tdata, 8'h00};
				push_grp.pad   = 2'd1;
			end
			default: begin
				push_grp.chunk = {held_q, s_tdata};
				push_grp.pad   = 2'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 2'd0;
		end else if (accept) begin
			if (complete)
				fill_q <= 2'd0;
			else
				fill_q <= fill_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !complete) begin
			if (fill_q == 2'd0)
				held_q[15:8] <= s_tdata;
			else
				held_q[7:0] <= s_tdata;
		end
	end

endmodule
`default_nettype wire

[rtl/b64e_queue.sv]
`default_nettype none
module b64e_queue
	import b64e_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  wire grp_t push_grp,
	output logic      pop_valid,
	input  wire logic pop_ready,
	output grp_t      pop_grp
);

	localparam logic [QPTR_W:0] FULL = (QPTR_W + 1)'(QDEPTH);

	grp_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (cnt_q != FULL);
	assign pop_valid  = (cnt_q != '0);
	assign pop_grp    = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= next_ptr(wr_q);
			if (do_pop)
				rd_q <= next_ptr(rd_q);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_grp;
	end

endmodule
`default_nettype wire

[rtl/b64e_back.sv]
`default_nettype none
module b64e_back
	import b64e_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] line_lim,
	input  wire logic       pop_valid,
	output logic            pop_ready,
	input  wire grp_t       pop_grp,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,
	output logic            m_tlast
);

	grp_t       g_q;
	logic       g_valid_q;
	logic [1:0] idx_q;     // wraps to 0 after the fourth char
	logic       lf_q;      // CR sent, LF owed
	logic [7:0] col_q;
	logic       can_emit;
	logic       brk;
	logic       last_char;
	logic [5:0] sext;
	logic [7:0] ch;
	logic       is_pad;

	assign can_emit  = g_valid_q && (!m_tvalid || m_tready);
	assign brk       = (col_q >= line_lim);
	assign last_char = can_emit && !lf_q && !brk && (idx_q == 2'd3);
	assign pop_ready = !g_valid_q || last_char;

	always_comb begin
		case (idx_q)
			2'd0:    sext = g_q.chunk[23:18];
			2'd1:    sext = g_q.chunk[17:12];
			2'd2:    sext = g_q.chunk[11:6];
			default: sext = g_q.chunk[5:0];
		endcase
		is_pad = ((idx_q == 2'd2) && (g_q.pad > 2'd1)) ||
		         ((idx_q == 2'd3) && (g_q.pad != 2'd0));
		ch = is_pad ? PAD_CHAR : b64_char(sext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_valid_q <= 1'b0;
			idx_q     <= 2'd0;
			lf_q      <= 1'b0;
			col_q     <= 8'd0;
			m_tvalid  <= 1'b0;
		end else begin
			if (can_emit)
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
			if (can_emit) begin
				if (lf_q) begin
					lf_q <= 1'b0;
				end else if (brk) begin
					lf_q  <= 1'b1;
					col_q <= 8'd0;
				end else begin
					idx_q <= idx_q + 2'd1;
					if (idx_q == 2'd3 && g_q.fin)
						col_q <= 8'd0;
					else
						col_q <= col_q + 8'd1;
				end
			end
			if (pop_ready)
				g_valid_q <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid)
			g_q <= pop_grp;
		if (can_emit) begin
			if (lf_q) begin
				m_tdata <= LF_CHAR;
				m_tlast <= 1'b0;
			end else if (brk) begin
				m_tdata <= CR_CHAR;
				m_tlast <= 1'b0;
			end else begin
				m_tdata <= ch;
				m_tlast <= (idx_q == 2'd3) && g_q.fin;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/base64_line_wrapped_encoder.sv]
// channel | dir | handshake          | payload
// s       | in  | s_tvalid/s_tready  | s_tdata[7:0] data_byte, s_tlast final_byte
// m       | out | m_tvalid/m_tready  | m_tdata[7:0] out_char, m_tlast end_of_message
// cfg     | in  | cfg_valid/cfg_ready| cfg_data[7:0] line_length (always ready)
//
// Input takes one item per cycle while the two-entry group queue has room.
// Output gives one item per cycle while m_tready is high and a group is queued:
// four characters per group plus two per line break (CR then LF); the
// single-character output register sets the sustained rate.
// Reset (arst_n low, async) empties the queue, clears column and fill, and
// sets line length to 76. A stalled output stalls the back end only; the
// front keeps taking bytes until the queue fills.
`default_nettype none
module base64_line_wrapped_encoder
	import b64e_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,    // [7:0] data_byte
	input  wire logic       s_tlast,    // final_byte
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,    // [7:0] out_char
	output logic            m_tlast,    // end_of_message
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_data    // [7:0] line_length
);

	// effective line limit, already clamped to at least 4 on write
	logic [7:0] lim_q;
	logic       push_valid;
	logic       push_ready;
	grp_t       push_grp;
	logic       pop_valid;
	logic       pop_ready;
	grp_t       pop_grp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= LINE_LEN_RST;
		end else if (cfg_valid) begin
			lim_q <= (cfg_data < MIN_LINE) ? MIN_LINE : cfg_data;
		end
	end

	// front: byte gathering into groups
	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_grp   (push_grp)
	);

	// decoupling queue between front and back
	b64e_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_grp   (push_grp),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_grp    (pop_grp)
	);

	// back: character emission, line breaks, output register
	b64e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.line_lim  (lim_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_grp   (pop_grp),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire

[rtl/b64e_checker.sv]
`default_nettype none
`include "base64_line_wrapped_encoder_macros.svh"
module b64e_checker
	import b64e_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic       m_tlast
);

	`B64E_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`B64E_ASSERT_NXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))
	`B64E_ASSERT_IMP(a_last_not_brk, clk, arst_n, m_tvalid && m_tlast, m_tdata != CR_CHAR && m_tdata != LF_CHAR)
	`B64E_ASSERT_IMP(a_char_nonzero, clk, arst_n, m_tvalid, m_tdata != 8'h00)

endmodule

bind base64_line_wrapped_encoder b64e_checker u_b64e_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
`default_nettype wire
